FILE: rtl/analog_input_qualifier_assert.svh
// assertion macros for the analog input qualifier
// expects clk_i and rst_ni in the scope of use
`ifndef ANALOG_INPUT_QUALIFIER_ASSERT_SVH
`define ANALOG_INPUT_QUALIFIER_ASSERT_SVH

// same-cycle implication
`define AIQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AIQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/aiq_pkg.sv
// shared types, constants and the bus code function of the analog input qualifier
// no dependencies
package aiq_pkg;

  localparam int unsigned NUM_LANES   = 4;
  localparam int unsigned NUM_CH      = 5;
  localparam int unsigned SAMPLE_W    = 12;
  localparam int unsigned SERIAL_W    = 8;
  localparam int unsigned CH_W        = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned SCALED_W    = SAMPLE_W + 8;   // sample * 255
  localparam int unsigned SCALE_SHIFT = 36;             // exact for full scale up to 2^16
  localparam int unsigned RECIP_W     = 29;             // ceil(2^36 / 255) fits
  localparam int unsigned SAMPLE_FULL_SCALE_DEF = 4095;

  localparam logic [CH_W-1:0] LAST_CH = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UV_THRESH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_CH0   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_CH1   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_CH2   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_CH3   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CODING_MASK = 3'd6;

  // coding mask bits
  localparam int unsigned MASK_SERIAL = 0;
  localparam int unsigned MASK_SER3   = 1;
  localparam int unsigned MASK_CH3    = 2;
  localparam int unsigned MASK_CH1    = 3;

  // diagnostic event codes
  localparam logic [1:0] DTC_NONE  = 2'd0;
  localparam logic [1:0] DTC_SET   = 2'd1;
  localparam logic [1:0] DTC_CLEAR = 2'd2;

  // fault report status
  localparam logic [1:0] ST_NO_FAULT = 2'd0;
  localparam logic [1:0] ST_PENDING  = 2'd1;
  localparam logic [1:0] ST_REPORTED = 2'd2;

  localparam logic [SAMPLE_W-1:0] FAULT_VALUE  = 12'd255;
  localparam logic [SAMPLE_W-1:0] LVL_CH0_LO   = 12'd1500;
  localparam logic [SAMPLE_W-1:0] LVL_CH0_HI   = 12'd4000;
  localparam logic [SAMPLE_W-1:0] LVL_CH2_LO   = 12'd1200;
  localparam logic [SAMPLE_W-1:0] LVL_CH2_MID  = 12'd2000;
  localparam logic [SAMPLE_W-1:0] LVL_CH2_HI   = 12'd4000;
  localparam logic [SAMPLE_W-1:0] LVL_SWITCH   = 12'd3000;
  localparam logic [SERIAL_W-1:0] SER_MASKED_V = 8'h03;
  localparam logic [7:0]          SCALE_MAX    = 8'hFF;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_0;
    logic [SAMPLE_W-1:0] sample_1;
    logic [SAMPLE_W-1:0] sample_2;
    logic [SAMPLE_W-1:0] sample_3;
    logic [SERIAL_W-1:0] serial_value;
    logic                adc_fault;
    logic                serial_fault;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] processed_value;
    logic [7:0]          raw_scaled;
    logic [7:0]          bus_code;
    logic                fault;
    logic [1:0]          dtc_event;
    logic                last;
  } out_item_t;

  // per-channel result held until it leaves
  typedef struct packed {
    logic [SAMPLE_W-1:0] processed_value;
    logic [7:0]          raw_scaled;
    logic [7:0]          bus_code;
    logic                fault;
    logic [1:0]          dtc_event;
  } lane_res_t;

  typedef struct packed {
    logic [7:0]  uv_thresh;
    logic [7:0]  debounce;
    logic [15:0] floor_ch0;
    logic [15:0] floor_ch1;
    logic [15:0] floor_ch2;
    logic [15:0] floor_ch3;
    logic [3:0]  coding_mask;
  } cfg_t;

  function automatic logic [7:0] level_code(int unsigned lane, logic [SAMPLE_W-1:0] proc,
                                            logic [3:0] mask);
    logic [7:0] code;
    code = 8'd0;
    case (lane)
      0: begin
        if (proc >= LVL_CH0_HI) code = 8'd2;
        else if (proc >= LVL_CH0_LO) code = 8'd1;
      end
      1: begin
        if (proc >= LVL_SWITCH && !mask[MASK_CH1]) code = 8'd1;
      end
      2: begin
        if (proc >= LVL_CH2_HI) code = 8'd3;
        else if (proc >= LVL_CH2_MID) code = 8'd2;
        else if (proc >= LVL_CH2_LO) code = 8'd1;
      end
      3: begin
        if (proc >= LVL_SWITCH && !mask[MASK_CH3]) code = 8'd1;
      end
      default: code = 8'd0;
    endcase
    return code;
  endfunction

endpackage

FILE: rtl/aiq_if.sv
// valid/ready stream interfaces for input items and result items
// depends on aiq_pkg
interface aiq_in_if;
  logic               valid;
  logic               ready;
  aiq_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface aiq_out_if;
  logic               valid;
  logic               ready;
  aiq_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/aiq_lane.sv
// one converter channel: debounce counter and fault latch (active on lanes 1 and 3 only), floor, scaling, bus code
// depends on aiq_pkg
module aiq_lane #(
  parameter int unsigned LANE              = 0,
  parameter int unsigned SAMPLE_FULL_SCALE = aiq_pkg::SAMPLE_FULL_SCALE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          take_i,
  input  logic [aiq_pkg::SAMPLE_W-1:0]  sample_i,
  input  aiq_pkg::cfg_t                 cfg_i,
  input  logic [15:0]                   floor_i,
  output aiq_pkg::lane_res_t            res_o
);
  import aiq_pkg::*;

  localparam bit COUNTS = (LANE == 1) || (LANE == 3);
  localparam int unsigned PROD_W = SCALED_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SCALE_SHIFT) + 64'(SAMPLE_FULL_SCALE) - 64'd1) / 64'(SAMPLE_FULL_SCALE);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
  localparam int unsigned QUO_W = PROD_W - SCALE_SHIFT;

  logic [7:0] low_count_q, low_count_d, cnt_inc;
  logic [1:0] status_q, status_d, status_mid;
  logic       latch_q, latch_d;
  logic       cnt_en;

  logic [SCALED_W-1:0] scaled;
  logic [PROD_W-1:0]   prod;
  logic [QUO_W-1:0]    quo;
  logic [SAMPLE_W-1:0] proc;

  always_comb begin
    cnt_inc     = low_count_q + 8'd1;
    cnt_en      = COUNTS && (status_q == ST_NO_FAULT) && ({4'd0, cfg_i.uv_thresh} > sample_i);
    low_count_d = low_count_q;
    status_mid  = status_q;
    latch_d     = latch_q;
    if (cnt_en) begin
      if (cnt_inc == cfg_i.debounce) begin
        low_count_d = 8'd0;
        status_mid  = ST_PENDING;
        latch_d     = 1'b1;
      end else begin
        low_count_d = cnt_inc;
      end
    end

    if (latch_d) proc = FAULT_VALUE;
    else if ({4'd0, sample_i} <= floor_i) proc = '0;
    else proc = sample_i;

    status_d = status_mid;
    if (status_mid == ST_PENDING && latch_d) begin
      res_o.dtc_event = DTC_SET;
      status_d        = ST_REPORTED;
    end else if (!latch_d) begin
      res_o.dtc_event = DTC_CLEAR;
    end else begin
      res_o.dtc_event = DTC_NONE;
    end

    // sample * 255 / full scale via exact reciprocal
    scaled = {sample_i, 8'd0} - SCALED_W'(sample_i);
    prod   = PROD_W'(scaled) * PROD_W'(RECIP);
    quo    = prod[PROD_W-1:SCALE_SHIFT];

    res_o.processed_value = proc;
    res_o.raw_scaled      = (quo > QUO_W'(SCALE_MAX)) ? SCALE_MAX : quo[7:0];
    res_o.bus_code        = level_code(LANE, proc, cfg_i.coding_mask);
    res_o.fault           = latch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_count_q <= 8'd0;
      status_q    <= ST_NO_FAULT;
      latch_q     <= 1'b0;
    end else if (take_i) begin
      low_count_q <= low_count_d;
      status_q    <= status_d;
      latch_q     <= latch_d;
    end
  end

endmodule

FILE: rtl/aiq_merge.sv
// collects the lane results of one transaction and sends them out one per cycle while out_if.ready is high
// depends on aiq_pkg and aiq_out_if
module aiq_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  aiq_pkg::lane_res_t res_i [aiq_pkg::NUM_CH],
  output logic               space_o,
  aiq_out_if.source          out_if
);
  import aiq_pkg::*;

  lane_res_t       pend_q [NUM_CH];
  lane_res_t       act_q  [NUM_CH];
  logic            pend_vld_q, act_vld_q;
  logic [CH_W-1:0] idx_q;
  logic            out_fire, act_free;
  lane_res_t       cur;

  assign space_o  = !pend_vld_q;
  assign out_fire = act_vld_q && out_if.ready;
  assign act_free = !act_vld_q || (out_fire && idx_q == LAST_CH);
  assign cur      = act_q[idx_q];

  always_comb begin
    out_if.valid                = act_vld_q;
    out_if.data.channel         = idx_q;
    out_if.data.processed_value = cur.processed_value;
    out_if.data.raw_scaled      = cur.raw_scaled;
    out_if.data.bus_code        = cur.bus_code;
    out_if.data.fault           = cur.fault;
    out_if.data.dtc_event       = cur.dtc_event;
    out_if.data.last            = (idx_q == LAST_CH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      act_vld_q  <= 1'b0;
      idx_q      <= '0;
    end else if (act_free) begin
      idx_q <= '0;
      if (pend_vld_q) begin
        act_vld_q  <= 1'b1;
        pend_vld_q <= load_i;
      end else begin
        act_vld_q <= load_i;
      end
    end else begin
      if (out_fire) idx_q <= idx_q + CH_W'(1);
      if (load_i) pend_vld_q <= 1'b1;
    end
  end

  // payload banks
  always_ff @(posedge clk_i) begin
    if (act_free && pend_vld_q) begin
      act_q <= pend_q;
      if (load_i) pend_q <= res_i;
    end else if (act_free && load_i) begin
      act_q <= res_i;
    end else if (load_i) begin
      pend_q <= res_i;
    end
  end

endmodule

FILE: rtl/analog_input_qualifier.sv
// analog input qualifier: one transaction in gives five results out, channel 0 first.
// latency: the channel 0 result is valid the cycle after acceptance on an idle block.
// throughput: one result per cycle on the output port while out_if.ready is high;
// one transaction waits in a buffer while the previous one drains.
// reset clears registers, counters, report status, fault latches and both buffers.
`include "analog_input_qualifier_assert.svh"
module analog_input_qualifier #(
  parameter int unsigned SAMPLE_FULL_SCALE = aiq_pkg::SAMPLE_FULL_SCALE_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [aiq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [aiq_pkg::CFG_DATA_W-1:0] cfg_data_i,
  aiq_in_if.sink                         in_if,
  aiq_out_if.source                      out_if
);
  import aiq_pkg::*;

  cfg_t                cfg_q;
  logic                ser_latch_q, ser_latch_d;
  logic                in_fire, space;
  logic [SAMPLE_W-1:0] samp [NUM_LANES];
  logic [15:0]         floors [NUM_LANES];
  logic [SERIAL_W-1:0] ser_eff;
  lane_res_t           ser_res;
  lane_res_t           res [NUM_CH];

  assign in_if.ready = space;
  assign in_fire     = in_if.valid && space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_UV_THRESH:   cfg_q.uv_thresh   <= cfg_data_i[7:0];
        REG_DEBOUNCE:    cfg_q.debounce    <= cfg_data_i[7:0];
        REG_FLOOR_CH0:   cfg_q.floor_ch0   <= cfg_data_i;
        REG_FLOOR_CH1:   cfg_q.floor_ch1   <= cfg_data_i;
        REG_FLOOR_CH2:   cfg_q.floor_ch2   <= cfg_data_i;
        REG_FLOOR_CH3:   cfg_q.floor_ch3   <= cfg_data_i;
        REG_CODING_MASK: cfg_q.coding_mask <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // converter fault forces every sample to zero
  always_comb begin
    samp[0]   = in_if.data.adc_fault ? '0 : in_if.data.sample_0;
    samp[1]   = in_if.data.adc_fault ? '0 : in_if.data.sample_1;
    samp[2]   = in_if.data.adc_fault ? '0 : in_if.data.sample_2;
    samp[3]   = in_if.data.adc_fault ? '0 : in_if.data.sample_3;
    floors[0] = cfg_q.floor_ch0;
    floors[1] = cfg_q.floor_ch1;
    floors[2] = cfg_q.floor_ch2;
    floors[3] = cfg_q.floor_ch3;
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    aiq_lane #(
      .LANE              (g),
      .SAMPLE_FULL_SCALE (SAMPLE_FULL_SCALE)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .take_i   (in_fire),
      .sample_i (samp[g]),
      .cfg_i    (cfg_q),
      .floor_i  (floors[g]),
      .res_o    (res[g])
    );
  end

  // serial channel
  always_comb begin
    ser_eff     = (in_if.data.adc_fault || in_if.data.serial_fault) ? '0
                                                                    : in_if.data.serial_value;
    ser_latch_d = ser_latch_q || in_if.data.serial_fault;
    ser_res.processed_value = SAMPLE_W'(ser_eff);
    ser_res.raw_scaled      = 8'd0;
    ser_res.fault           = ser_latch_d;
    ser_res.dtc_event       = DTC_NONE;
    if (cfg_q.coding_mask[MASK_SERIAL] ||
        (cfg_q.coding_mask[MASK_SER3] && ser_eff == SER_MASKED_V)) begin
      ser_res.bus_code = 8'd0;
    end else begin
      ser_res.bus_code = ser_eff;
    end
  end

  assign res[LAST_CH] = ser_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_latch_q <= 1'b0;
    end else if (in_fire) begin
      ser_latch_q <= ser_latch_d;
    end
  end

  aiq_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_fire),
    .res_i   (res),
    .space_o (space),
    .out_if  (out_if)
  );

  `AIQ_ASSERT_NEXT(a_channel_order, out_if.valid && out_if.ready && !out_if.data.last,
    out_if.valid && out_if.data.channel == $past(out_if.data.channel) + 3'd1,
    "results of a transaction left out of channel order")
  `AIQ_ASSERT_NEXT(a_idle_start, in_fire && !out_if.valid,
    out_if.valid && out_if.data.channel == 3'd0,
    "transaction on an idle block did not start at channel 0")
  `AIQ_ASSERT_NEXT(a_serial_latch_holds, ser_latch_q, ser_latch_q,
    "serial fault latch cleared")
  `AIQ_ASSERT_NOW(a_set_has_fault, out_if.valid && out_if.data.dtc_event == DTC_SET,
    out_if.data.fault && out_if.data.channel != LAST_CH,
    "fault-set report without a latched converter fault")

endmodule
